// ===== design/orb_pkg.sv =====
// ----------------------------------------------------------------------------
// orb_pkg - shared types and constants for the overwriting ring buffer
// Holds the ring geometry, the operation and status codes, the request and
// result payload structs and the pointer-advance helper.
// ----------------------------------------------------------------------------
package orb_pkg;

    // ring geometry
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int FUNC_W = 3;
    localparam int POS_W  = 4;
    localparam int CAP_W  = 5;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_NEWEST = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVERWR  = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [WORD_BITS-1:0] data_in;
        logic [POS_W-1:0]     position;
    } t_in;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic [STAT_W-1:0]    status;
        logic [OCC_W-1:0]     occupancy;
        logic                 is_full;
        logic                 is_empty;
    } t_out;

    // per-transfer result info that travels beside the memory read
    typedef struct packed {
        logic              use_mem;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  occupancy;
        logic              is_full;
        logic              is_empty;
    } t_meta;

    // next pointer position, wrapping at the capacity in use
    function automatic logic [CNT_W-1:0] ptr_adv(input logic [CNT_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] nxt;
        nxt = {1'b0, p} + 1'b1;
        ptr_adv = (nxt >= {1'b0, cap}) ? '0 : nxt[CNT_W-1:0];
    endfunction

endpackage

// ===== design/orb_ram.sv =====
// ----------------------------------------------------------------------------
// orb_ram - entry store
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that updates only when a read is issued.
// ----------------------------------------------------------------------------
module orb_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/orb_ctrl.sv =====
// ----------------------------------------------------------------------------
// orb_ctrl - pointer and count control
// Holds the capacity register, write/read pointers and entry count. Decodes
// each request, updates the pointers, and issues the RAM write or read.
// ----------------------------------------------------------------------------
module orb_ctrl
    import orb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  t_in                  i_req,
    input  logic                 i_cfg_wr_en,
    input  logic [CAP_W-1:0]     i_cfg_wr_data,
    output logic                 o_mem_we,
    output logic [PTR_W-1:0]     o_mem_waddr,
    output logic [WORD_BITS-1:0] o_mem_wdata,
    output logic                 o_mem_re,
    output logic [PTR_W-1:0]     o_mem_raddr,
    output t_meta                o_meta
);

    logic [CAP_W-1:0] r_cap, n_cap;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] wp_c, rp_c, cnt_c;
    logic [CNT_W:0]   peek_sum;
    logic [CNT_W:0]   peek_idx;
    logic [CNT_W-1:0] new_idx;

    // clamp capacity to 1..DEPTH
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (32'(r_cap) > DEPTH) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(r_cap);
        end
    end

    // current state, reset to empty if it lies outside the capacity
    always_comb begin
        wp_c  = CNT_W'(r_wp);
        rp_c  = CNT_W'(r_rp);
        cnt_c = r_cnt;
        if (wp_c >= cap_eff || rp_c >= cap_eff || cnt_c > cap_eff) begin
            wp_c  = '0;
            rp_c  = '0;
            cnt_c = '0;
        end
    end

    // read addresses for peek and read-newest
    assign peek_sum = {1'b0, rp_c} + (CNT_W + 1)'(i_req.position);
    assign peek_idx = (peek_sum >= {1'b0, cap_eff}) ? peek_sum - {1'b0, cap_eff} : peek_sum;
    assign new_idx  = (wp_c == '0) ? cap_eff - 1'b1 : wp_c - 1'b1;

    // request decode
    always_comb begin
        logic [CNT_W-1:0] wp_n, rp_n, cnt_n;
        logic [STAT_W-1:0] stat;
        logic use_mem;
        logic [PTR_W-1:0] raddr;
        wp_n    = wp_c;
        rp_n    = rp_c;
        cnt_n   = cnt_c;
        stat    = STAT_OK;
        use_mem = 1'b0;
        raddr   = peek_idx[PTR_W-1:0];
        case (i_req.func)
            FUNC_PUSH: begin
                wp_n = ptr_adv(wp_c, cap_eff);
                if (cnt_c < cap_eff) begin
                    cnt_n = cnt_c + 1'b1;
                end else begin
                    rp_n = ptr_adv(rp_c, cap_eff);
                    stat = STAT_OVERWR;
                end
            end
            FUNC_POP: begin
                if (cnt_c == '0) begin
                    stat = STAT_EMPTY;
                end else begin
                    rp_n  = ptr_adv(rp_c, cap_eff);
                    cnt_n = cnt_c - 1'b1;
                end
            end
            FUNC_FLUSH: begin
                wp_n  = '0;
                rp_n  = '0;
                cnt_n = '0;
            end
            FUNC_PEEK: begin
                if (32'(i_req.position) >= 32'(cnt_c)) begin
                    stat = STAT_RANGE;
                end else begin
                    use_mem = 1'b1;
                end
            end
            FUNC_NEWEST: begin
                raddr = new_idx[PTR_W-1:0];
                if (cnt_c == '0) begin
                    stat = STAT_EMPTY;
                end else begin
                    use_mem = 1'b1;
                end
            end
            default: begin
            end
        endcase

        o_meta.use_mem   = use_mem;
        o_meta.status    = stat;
        o_meta.occupancy = cnt_n;
        o_meta.is_full   = (cnt_n == cap_eff);
        o_meta.is_empty  = (cnt_n == '0);

        o_mem_we    = i_acc && (i_req.func == FUNC_PUSH);
        o_mem_waddr = wp_c[PTR_W-1:0];
        o_mem_wdata = i_req.data_in;
        o_mem_re    = i_acc && use_mem;
        o_mem_raddr = raddr;

        n_cap = r_cap;
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_cfg_wr_en) begin
            n_cap = i_cfg_wr_data;
            n_wp  = '0;
            n_rp  = '0;
            n_cnt = '0;
        end else if (i_acc) begin
            n_wp  = wp_n[PTR_W-1:0];
            n_rp  = rp_n[PTR_W-1:0];
            n_cnt = cnt_n;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cap <= n_cap;
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // count stays within the capacity in use
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cap_eff)
        else $error("entry count above capacity");

    // pointers stay inside the ring
    a_ptr_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_wp) < cap_eff) && (CNT_W'(r_rp) < cap_eff))
        else $error("pointer outside capacity");

    // a capacity write empties the ring
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_cnt == '0) && (r_wp == '0) && (r_rp == '0))
        else $error("capacity write did not clear the ring");

    // push on a full ring keeps the count and moves the read pointer, unless the capacity is 1
    a_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && !i_cfg_wr_en && i_req.func == FUNC_PUSH && r_cnt == cap_eff)
        |=> (r_cnt == $past(r_cnt)) && (r_rp != $past(r_rp) || $past(cap_eff) == CNT_W'(1)))
        else $error("overwrite did not drop the oldest entry");

endmodule

// ===== design/orb_out.sv =====
// ----------------------------------------------------------------------------
// orb_out - result stage and output register
// Holds the request info in stage 1 beside the registered RAM read data, pairs
// the two as stage 1 advances, and holds the finished result in an output register until it is taken.
// ----------------------------------------------------------------------------
module orb_out
    import orb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  t_meta                i_meta,
    input  logic [WORD_BITS-1:0] i_rdata,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output t_out                 o_out_data
);

    logic  r_s1_vld, n_s1_vld;
    t_meta r_s1_meta;
    logic  r_out_vld, n_out_vld;
    t_out  r_out_data;
    logic  out_free;
    logic  s1_adv;

    // stage 1 moves on when the output register is free or being drained
    assign out_free   = !r_out_vld || i_out_ready;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_ready = !r_s1_vld || out_free;

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (i_acc) begin
            n_s1_vld = 1'b1;
        end else if (s1_adv) begin
            n_s1_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (s1_adv) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_meta <= i_meta;
        end
        if (s1_adv) begin
            r_out_data.read_data <= r_s1_meta.use_mem ? i_rdata : '0;
            r_out_data.status    <= r_s1_meta.status;
            r_out_data.occupancy <= OCC_W'(r_s1_meta.occupancy);
            r_out_data.is_full   <= r_s1_meta.is_full;
            r_out_data.is_empty  <= r_s1_meta.is_empty;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // no transfer is taken while stage 1 is blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_free) |-> !i_acc)
        else $error("stage 1 overrun");

    // a stalled stage 1 keeps its info
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_free) |=> r_s1_vld && $stable(r_s1_meta))
        else $error("stage 1 lost a result");

    // every accepted transfer reaches stage 1
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |=> r_s1_vld)
        else $error("accepted transfer not tracked");

endmodule

// ===== design/overwriting_ring_buffer.sv =====
// A result passes through stage 1, beside the registered RAM read, and then the
// output register before it is valid; either one holds it while the reply side stalls.
// Throughput: one request per cycle while results are taken; the next request may
// enter while a result waits, until stage 1 and the output register are both full.
// Reset (synchronous, active low): ring empty, pointers zero, capacity 16.
// A capacity write also empties the ring. The entry store is not cleared.
// ----------------------------------------------------------------------------
// overwriting_ring_buffer - top level
// Ring buffer with push, pop, flush, peek and read-newest; a push on a full
// ring overwrites the oldest entry.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer
    import orb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data
);

    logic                 acc;
    logic                 mem_we;
    logic [PTR_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [PTR_W-1:0]     mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    t_meta                meta;

    assign acc = i_in_valid && o_in_ready;

    orb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_req         (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .o_meta        (meta)
    );

    orb_ram #(
        .ADDR_W (PTR_W),
        .DATA_W (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    orb_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_meta      (meta),
        .i_rdata     (mem_rdata),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sim/overwriting_ring_buffer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_tb - self-checking bench for the overwriting ring
// Drives push, pop, flush, peek and read-newest requests through the
// valid/ready request channel and checks each reply against a cycle-free
// model of the ring. Capacity is rewritten between phases, and both sides
// stall at random, including one long stall on the reply side.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_tb;
    import orb_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int SEG_ITEMS    = 125;
    localparam int NUM_SEGS     = 8;
    localparam int HOLD_AT      = 300;   // request count that starts the long stall
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;  // cycles with no transfer before giving up
    localparam int SETTLE       = 8;     // cycles after the last reply
    localparam int IDLE_LIGHT   = 16;
    localparam int IDLE_HEAVY   = 80;

    // DUT ports
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_ready;
    t_in              i_in_data     = '0;
    logic             o_out_valid;
    logic             i_out_ready   = 1'b0;
    t_out             o_out_data;
    logic             i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] i_cfg_wr_data = CAP_RESET;

    // ring model state
    logic [WORD_BITS-1:0] ring_mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr  = '0;
    logic [PTR_W-1:0]     rd_ptr  = '0;
    logic [CNT_W-1:0]     fill    = '0;
    logic [CAP_W-1:0]     cap_reg = CAP_RESET;

    // request and reply bookkeeping
    t_in  req_q   [$];
    t_out reply_q [$];
    int   n_in        = 0;
    int   n_out       = 0;
    int   n_over      = 0;
    int   n_cfg       = 0;
    int   mismatches  = 0;
    int   send_idle   = 0;
    int   recv_idle   = 0;
    int   hold_left   = 0;
    bit   hold_done   = 1'b0;
    int   stall_count = 0;

    overwriting_ring_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // capacity after clamping to 1..DEPTH
    function automatic int ring_capacity();
        if (cap_reg == 0) return 1;
        if (cap_reg > DEPTH) return DEPTH;
        return int'(cap_reg);
    endfunction

    // apply one request to the ring model and return the reply it produces
    function automatic t_out ring_apply(input t_in req);
        int   cap;
        int   idx;
        t_out r;
        cap = ring_capacity();
        r   = '0;
        r.status = STAT_OK;
        if (wr_ptr >= cap || rd_ptr >= cap || fill > cap) begin
            wr_ptr = '0;
            rd_ptr = '0;
            fill   = '0;
        end
        case (req.func)
            FUNC_PUSH: begin
                ring_mem[wr_ptr] = req.data_in;
                wr_ptr = (int'(wr_ptr) + 1 >= cap) ? '0 : wr_ptr + 1'b1;
                if (fill < cap) begin
                    fill = fill + 1'b1;
                end else begin
                    // full: oldest entry is lost
                    rd_ptr   = (int'(rd_ptr) + 1 >= cap) ? '0 : rd_ptr + 1'b1;
                    r.status = STAT_OVERWR;
                end
            end
            FUNC_POP: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    rd_ptr = (int'(rd_ptr) + 1 >= cap) ? '0 : rd_ptr + 1'b1;
                    fill   = fill - 1'b1;
                end
            end
            FUNC_FLUSH: begin
                wr_ptr = '0;
                rd_ptr = '0;
                fill   = '0;
            end
            FUNC_PEEK: begin
                if (req.position >= fill) begin
                    r.status = STAT_RANGE;
                end else begin
                    idx = (int'(rd_ptr) + int'(req.position)) % cap;
                    r.read_data = ring_mem[idx];
                end
            end
            FUNC_NEWEST: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    idx = (int'(wr_ptr) + cap - 1) % cap;
                    r.read_data = ring_mem[idx];
                end
            end
            default: ;  // unused codes do nothing
        endcase
        r.occupancy = OCC_W'(fill);
        r.is_full   = (int'(fill) == cap);
        r.is_empty  = (fill == 0);
        return r;
    endfunction

    task automatic queue_req(input logic [FUNC_W-1:0] func,
                             input logic [WORD_BITS-1:0] data,
                             input logic [POS_W-1:0] pos);
        t_in req;
        req.func     = func;
        req.data_in  = data;
        req.position = pos;
        req_q.push_back(req);
    endtask

    // pushes are the most common request so the ring fills and wraps; half the positions fall inside the capacity
    task automatic queue_random(input int count);
        int                  pick;
        logic [FUNC_W-1:0]   func;
        logic [POS_W-1:0]    pos;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      func = FUNC_PUSH;
            else if (pick < 65) func = FUNC_POP;
            else if (pick < 85) func = FUNC_PEEK;
            else if (pick < 97) func = FUNC_NEWEST;
            else if (pick < 98) func = FUNC_FLUSH;
            else                func = FUNC_W'($urandom_range(5, 7));
            if ($urandom_range(0, 1) == 0)
                pos = POS_W'($urandom_range(0, ring_capacity() - 1));
            else
                pos = POS_W'($urandom());
            queue_req(func, $urandom(), pos);
        end
    endtask

    // hold until every queued request is sent and every reply is back
    task automatic wait_drained();
        while (req_q.size() != 0 || i_in_valid || reply_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // capacity write; the ring empties as on a flush
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_reg = value;
        wr_ptr  = '0;
        rd_ptr  = '0;
        fill    = '0;
        n_cfg++;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // request driver: one transfer per handshake, idles at random
    always @(posedge i_clk) begin
        t_out reply;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                reply = ring_apply(i_in_data);
                if (reply.status == STAT_OVERWR) n_over <= n_over + 1;
                reply_q.push_back(reply);
                n_in <= n_in + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= req_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // reply-side ready: random idling plus one long stall
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && n_in >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // reply monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_out <= n_out + 1;
            if (reply_q.size() == 0) begin
                mismatches++;
                $display("%0t: reply with none pending, expected nothing, actual %0h",
                         $time, o_out_data);
            end else begin
                want = reply_q.pop_front();
                check_field("read_data", want.read_data, o_out_data.read_data);
                check_field("status",    want.status,    o_out_data.status);
                check_field("occupancy", want.occupancy, o_out_data.occupancy);
                check_field("is_full",   want.is_full,   o_out_data.is_full);
                check_field("is_empty",  want.is_empty,  o_out_data.is_empty);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_count <= 0;
        end else if (stall_count == STALL_LIMIT) begin
            $display("overwriting_ring_buffer verification failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // stimulus sequence
    initial begin
        logic [CAP_W-1:0] caps [NUM_SEGS];
        caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd9, 5'd15};
        caps[5] = CAP_W'($urandom_range(2, 8));
        caps[6] = CAP_W'($urandom_range(9, 15));

        send_idle = IDLE_LIGHT;
        recv_idle = IDLE_HEAVY;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-ring cases, extreme words, unused codes, flush
        queue_req(FUNC_PEEK,   '0, 4'd0);
        queue_req(FUNC_POP,    '0, 4'd0);
        queue_req(FUNC_NEWEST, '0, 4'd0);
        queue_req(FUNC_PUSH,   32'h0000_0000, 4'd0);
        queue_req(FUNC_PUSH,   32'hFFFF_FFFF, 4'd15);
        queue_req(FUNC_PUSH,   32'hA5A5_5A5A, 4'd0);
        queue_req(FUNC_PEEK,   '0, 4'd0);
        queue_req(FUNC_PEEK,   '0, 4'd2);
        queue_req(FUNC_PEEK,   '0, 4'd3);
        queue_req(FUNC_PEEK,   '0, 4'd15);
        queue_req(FUNC_NEWEST, '0, 4'd0);
        queue_req(3'd5,        32'hFFFF_FFFF, 4'd15);
        queue_req(3'd6,        '0, 4'd0);
        queue_req(3'd7,        32'h1234_5678, 4'd7);
        queue_req(FUNC_POP,    '0, 4'd0);
        queue_req(FUNC_PEEK,   '0, 4'd0);
        queue_req(FUNC_FLUSH,  '0, 4'd0);
        queue_req(FUNC_NEWEST, '0, 4'd0);
        wait_drained();

        // directed: single-entry ring overwrites on every push past the first
        write_capacity(5'd1);
        queue_req(FUNC_PUSH,   32'h0000_1234, 4'd0);
        queue_req(FUNC_PUSH,   32'h0000_5678, 4'd0);
        queue_req(FUNC_NEWEST, '0, 4'd0);
        queue_req(FUNC_PEEK,   '0, 4'd0);
        queue_req(FUNC_PEEK,   '0, 4'd1);
        queue_req(FUNC_POP,    '0, 4'd0);
        queue_req(FUNC_POP,    '0, 4'd0);
        wait_drained();

        // random segments, one capacity each, idling pattern by phase
        for (int s = 0; s < NUM_SEGS; s++) begin
            if (s < 3) begin
                send_idle = IDLE_LIGHT;
                recv_idle = IDLE_HEAVY;
            end else if (s < 6) begin
                send_idle = IDLE_HEAVY;
                recv_idle = IDLE_LIGHT;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_capacity(caps[s]);
            queue_random(SEG_ITEMS);
            wait_drained();
        end

        $display("covered %0d requests and %0d replies over %0d capacity settings,",
                 n_in, n_out, n_cfg);
        $display("with %0d overwrites of the oldest entry and one long reply stall",
                 n_over);
        if (mismatches == 0) begin
            $display("overwriting_ring_buffer verification clean");
        end else begin
            $display("overwriting_ring_buffer verification failed");
        end
        $finish;
    end

endmodule
